FILE: hdl/websocket_frame_deframer_assert.svh
// Assertion helpers for the deframer checker.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsd assertion failed");

// Next-cycle implication.
`define WSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsd assertion failed");

`endif

FILE: hdl/wsd_pkg.sv
package wsd_pkg;

    // Width of the accumulated frame length and the remaining-byte counter.
    localparam int LEN_BITS = 32;
    localparam int FLEN_W   = 32;

    localparam logic [7:0] FIRST_BYTE_RST = 8'h82;
    localparam logic [7:0] LEN_CODE_16    = 8'h7E;
    localparam logic [6:0] LEN_SMALL_MAX  = 7'd125;

    // Result status codes
    localparam logic [2:0] ST_HEADER     = 3'd0;
    localparam logic [2:0] ST_PAYLOAD    = 3'd1;
    localparam logic [2:0] ST_SKIP       = 3'd2;
    localparam logic [2:0] ST_SKIP_AFTER = 3'd3;
    localparam logic [2:0] ST_MASKED     = 3'd4;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd5;

    // Register map
    localparam int          PADDR_W      = 3;
    localparam logic        REG_IDX_FIRST = 1'b0;

    // Byte plus the state-independent decode done by the front end.
    typedef struct packed {
        logic [7:0] data;
        logic       is_first;   // matches configured first header byte
        logic       masked;     // mask bit of the length byte
        logic       len_small;  // 7-bit length 0..125
        logic       len_zero;   // 7-bit length is zero
        logic       is_ext16;   // 16-bit extended length code
    } cls_t;

    function automatic logic [FLEN_W-1:0] to_flen(input logic [LEN_BITS-1:0] v);
        logic [LEN_BITS+FLEN_W-1:0] tmp;
        tmp = {{FLEN_W{1'b0}}, v};
        return tmp[FLEN_W-1:0];
    endfunction

endpackage

FILE: hdl/wsd_if.sv
interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [31:0] frame_length;

    modport source (output valid, output status, output payload_byte,
                    output frame_end, output frame_length, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input frame_end, input frame_length, output ready);
endinterface

FILE: hdl/wsd_front.sv
module wsd_front (
    wsd_byte_if.sink      stream,
    input  logic [7:0]    first_byte,
    output logic          item_valid,
    input  logic          item_ready,
    output wsd_pkg::cls_t item
);
    import wsd_pkg::*;

    assign item_valid   = stream.valid;
    assign stream.ready = item_ready;

    always_comb
    begin
        item.data      = stream.in_byte;
        item.is_first  = (stream.in_byte == first_byte);
        item.masked    = stream.in_byte[7];
        item.len_small = (stream.in_byte[6:0] <= LEN_SMALL_MAX);
        item.len_zero  = (stream.in_byte[6:0] == 7'd0);
        item.is_ext16  = (stream.in_byte == LEN_CODE_16);
    end
endmodule

FILE: hdl/wsd_queue.sv
module wsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  wsd_pkg::cls_t push_item,
    output logic          pop_valid,
    input  logic          pop_ready,
    output wsd_pkg::cls_t pop_item
);
    import wsd_pkg::*;

    cls_t       mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

FILE: hdl/wsd_back.sv
module wsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  wsd_pkg::cls_t item,
    wsd_result_if.source  result
);
    import wsd_pkg::*;

    localparam logic [2:0] PH_WAIT_OP = 3'd0;
    localparam logic [2:0] PH_LEN0    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]          phase_reg, phase_next;
    logic [3:0]          cnt_reg, cnt_next, cnt_inc;
    logic [LEN_BITS-1:0] len_reg, len_next, len_shift;
    logic [LEN_BITS-1:0] left_reg, left_next;
    logic                done_reg, done_next;

    logic                vld_reg;
    logic [2:0]          status_reg, status_next;
    logic [7:0]          pbyte_reg, pbyte_next;
    logic                fend_reg, fend_next;
    logic [FLEN_W-1:0]   flen_reg, flen_next;

    logic                advance;
    logic                ext_done;

    assign advance    = item_valid && (!vld_reg || result.ready);
    assign item_ready = advance;

    assign len_shift = {len_reg[LEN_BITS-9:0], item.data};
    assign cnt_inc   = cnt_reg + 4'd1;
    assign ext_done  = (phase_reg == PH_EXT16) ? (cnt_inc >= 4'd2) : (cnt_inc >= 4'd8);

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        left_next   = left_reg;
        done_next   = done_reg;
        status_next = ST_HEADER;
        pbyte_next  = 8'd0;
        fend_next   = 1'b0;
        flen_next   = '0;

        unique case (phase_reg)
            PH_LEN0:
            begin
                if (item.masked)
                begin
                    status_next = ST_MASKED;
                    done_next   = 1'b0;
                    phase_next  = PH_WAIT_OP;
                end
                else if (item.len_small)
                begin
                    len_next  = LEN_BITS'(item.data[6:0]);
                    flen_next = FLEN_W'(item.data[6:0]);
                    if (item.len_zero)
                    begin
                        fend_next  = 1'b1;
                        done_next  = 1'b1;
                        phase_next = PH_WAIT_OP;
                    end
                    else
                    begin
                        left_next  = LEN_BITS'(item.data[6:0]);
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    len_next   = '0;
                    cnt_next   = 4'd0;
                    phase_next = item.is_ext16 ? PH_EXT16 : PH_EXT64;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_next = len_shift;
                cnt_next = cnt_inc;
                if (ext_done)
                begin
                    cnt_next = 4'd0;
                    if (len_shift == '0)
                    begin
                        status_next = ST_ZERO_LEN;
                        phase_next  = PH_WAIT_OP;
                    end
                    else
                    begin
                        flen_next  = to_flen(len_shift);
                        left_next  = len_shift;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                // left_reg is never zero here: entry needs a nonzero length
                status_next = ST_PAYLOAD;
                pbyte_next  = item.data;
                flen_next   = to_flen(len_reg);
                left_next   = left_reg - LEN_BITS'(1);
                if (left_reg == LEN_BITS'(1))
                begin
                    fend_next  = 1'b1;
                    done_next  = 1'b1;
                    phase_next = PH_WAIT_OP;
                end
            end
            default:
            begin
                phase_next = PH_WAIT_OP;
                if (item.is_first)
                begin
                    done_next  = 1'b0;
                    len_next   = '0;
                    left_next  = '0;
                    cnt_next   = 4'd0;
                    phase_next = PH_LEN0;
                end
                else
                begin
                    status_next = done_reg ? ST_SKIP_AFTER : ST_SKIP;
                    done_next   = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_OP;
            cnt_reg   <= 4'd0;
            len_reg   <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                len_reg   <= len_next;
                left_reg  <= left_next;
                done_reg  <= done_next;
                vld_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            pbyte_reg  <= pbyte_next;
            fend_reg   <= fend_next;
            flen_reg   <= flen_next;
        end
    end

    assign result.valid        = vld_reg;
    assign result.status       = status_reg;
    assign result.payload_byte = pbyte_reg;
    assign result.frame_end    = fend_reg;
    assign result.frame_length = flen_reg;
endmodule

FILE: hdl/websocket_frame_deframer.sv
// Byte-serial WebSocket frame deframer. One stream byte in, one result item
// out, in order. It hunts for the configured first header byte (register 0,
// reset 0x82), rejects masked frames, decodes the 7-bit, 16-bit or 64-bit
// length (the 64-bit form keeps its low 32 bits) and marks the last payload
// byte with frame_end (for a 7-bit zero length, the length byte). Sustained
// rate is one byte per clock while the result side keeps taking items. A byte
// accepted from the stream is written into the two-entry queue; the parser
// takes it from there and loads the result register, from which the result
// item is taken. The parser decides every byte combinationally (phase,
// length and remaining count). A stalled result holds the output register
// and backs up into the queue, which keeps accepting bytes until both
// entries are full. Config is written over APB at byte address 0; write
// only while idle.
module websocket_frame_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    wsd_byte_if.sink                      stream,
    wsd_result_if.source                  result
);
    import wsd_pkg::*;

    logic [7:0] first_reg;
    logic       cfg_wr;

    logic       f_valid, f_ready;
    cls_t       f_item;
    logic       q_valid, q_ready;
    cls_t       q_item;

    // APB: single register, word index taken from paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_FIRST);
    assign prdata = (paddr[2] == REG_IDX_FIRST) ? {24'd0, first_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= FIRST_BYTE_RST;
        end
        else if (cfg_wr)
        begin
            first_reg <= pwdata[7:0];
        end
    end

    // Front: byte decode, no state
    wsd_front u_front (
        .stream     (stream),
        .first_byte (first_reg),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    // Decoupling queue
    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // Back: frame parser and result register
    wsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .result     (result)
    );
endmodule

FILE: hdl/wsd_checker.sv
`include "websocket_frame_deframer_assert.svh"

module wsd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  status,
    input logic [7:0]  payload_byte,
    input logic        frame_end,
    input logic [31:0] frame_length
);
    import wsd_pkg::*;

    logic hdr_or_data;

    assign hdr_or_data = (status == ST_HEADER) || (status == ST_PAYLOAD);

    `WSD_ASSERT_NOW(a_status_range, res_valid, status <= ST_ZERO_LEN)
    `WSD_ASSERT_NOW(a_data_only_payload, res_valid && (status != ST_PAYLOAD), payload_byte == 8'd0)
    `WSD_ASSERT_NOW(a_end_kind, res_valid && frame_end, hdr_or_data)
    `WSD_ASSERT_NOW(a_no_len_on_reject, res_valid && !hdr_or_data, frame_length == 32'd0)
    `WSD_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable({status, frame_length}))
endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .status       (result.status),
    .payload_byte (result.payload_byte),
    .frame_end    (result.frame_end),
    .frame_length (result.frame_length)
);
